// ----- design/so3ij_pkg.sv -----
package so3ij_pkg;

  // Q3.28 one, thresholds and scale factors
  localparam logic [31:0] ONE_Q28     = 32'h1000_0000;
  localparam logic [63:0] ANG_SMALL   = 64'd7205760;
  localparam logic [31:0] INV_4PI2    = 32'd3481369361;
  localparam logic [27:0] INV_2PI2    = 28'd217585585;
  localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

  // series tail coefficients, zeta(2k) - 1 - 4^-k in Q30, k = 1..9
  localparam logic [29:0] ZETA_TAIL [0:8] = '{
    30'd424057225, 30'd21285035, 30'd1844755, 30'd183724, 30'd19341,
    30'd2089, 30'd229, 30'd25, 30'd3
  };

  // divider depth: quotient bits of 2^60 / D
  localparam int unsigned DIV_N = 61;

  // data carried alongside the divider and coefficient stages
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [35:0] md0;
    logic [35:0] md1;
    logic [35:0] md2;
    logic [34:0] mxy;
    logic [34:0] mxz;
    logic [34:0] myz;
    logic        nxy;
    logic        nxz;
    logic        nyz;
    logic        tiny;
    logic        big;
    logic [29:0] u30;
    logic [29:0] acc;
  } side_t;

  // Q28 product magnitude rounded to nearest
  function automatic logic [34:0] rnd28(input logic [63:0] p);
    logic [63:0] t;
    t = p + 64'h0800_0000;
    return t[62:28];
  endfunction

  // floor(w / 2) of +v or -v, 33-bit signed
  function automatic logic signed [32:0] half_of(input logic signed [31:0] v,
                                                 input logic neg);
    logic signed [32:0] w;
    w = neg ? -{v[31], v} : {v[31], v};
    return w >>> 1;
  endfunction

  // clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [42:0] e);
    logic [31:0] r;
    if (e > 43'sd2147483647) r = SAT_POS;
    else if (e < -43'sd2147483648) r = SAT_NEG;
    else r = e[31:0];
    return r;
  endfunction

endpackage

// ----- design/so3_inverse_right_jacobian.sv -----
// Inverse right Jacobian of SO(3) for a rotation vector in signed Q3.28
// radians; returns the nine row-major entries in Q3.28 on out_tdata and an
// out-of-range flag on out_tuser. Fully pipelined: one request per cycle
// when not stalled. The path runs through four stages of squaring and angle
// scaling, the two pipelined restoring 2^60/D dividers (61 stages, one
// quotient bit each), six stages of coefficient and matrix assembly, and
// the output register.
// Angles below 1e-5 give the identity;
// angles at or past 2*pi give all entries at positive full scale with the
// flag set. The pipeline stalls only when its last stage and the output
// register are both full.
module so3_inverse_right_jacobian
  import so3ij_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // rot_x, rot_y, rot_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // j00, j01, j02, j10, j11, j12, j20, j21, j22
  output logic         out_tuser   // out_of_range
);

  localparam int unsigned NSTG = 4 + DIV_N + 6;

  logic [NSTG:1] vld_r;
  logic          en;
  logic          out_free;

  // stall control
  assign out_free  = !out_tvalid || out_tready;
  assign en        = !vld_r[NSTG] || out_free;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:1], in_tvalid};
    end
  end

  // stage 1: magnitudes squared and cross products
  logic signed [31:0] in_x, in_y, in_z;
  logic [31:0] ax, ay, az;
  assign in_x = in_tdata[31:0];
  assign in_y = in_tdata[63:32];
  assign in_z = in_tdata[95:64];
  assign ax = in_x[31] ? (~in_x + 32'd1) : in_x;
  assign ay = in_y[31] ? (~in_y + 32'd1) : in_y;
  assign az = in_z[31] ? (~in_z + 32'd1) : in_z;

  logic [63:0] s1_pxx_r, s1_pyy_r, s1_pzz_r, s1_pxy_r, s1_pxz_r, s1_pyz_r;
  logic        s1_nxy_r, s1_nxz_r, s1_nyz_r;
  logic signed [31:0] s1_x_r, s1_y_r, s1_z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pxx_r <= ax * ax;
      s1_pyy_r <= ay * ay;
      s1_pzz_r <= az * az;
      s1_pxy_r <= ax * ay;
      s1_pxz_r <= ax * az;
      s1_pyz_r <= ay * az;
      s1_nxy_r <= in_x[31] ^ in_y[31];
      s1_nxz_r <= in_x[31] ^ in_z[31];
      s1_nyz_r <= in_y[31] ^ in_z[31];
      s1_x_r   <= in_x;
      s1_y_r   <= in_y;
      s1_z_r   <= in_z;
    end
  end

  // stage 2: squared norm and rounded W^2 entries
  logic [63:0] s2_s_r;
  side_t       s2_side_r;
  side_t       s2_side_nxt;

  always_comb begin
    s2_side_nxt      = '0;
    s2_side_nxt.vx   = s1_x_r;
    s2_side_nxt.vy   = s1_y_r;
    s2_side_nxt.vz   = s1_z_r;
    s2_side_nxt.md0  = {1'b0, rnd28(s1_pyy_r)} + {1'b0, rnd28(s1_pzz_r)};
    s2_side_nxt.md1  = {1'b0, rnd28(s1_pxx_r)} + {1'b0, rnd28(s1_pzz_r)};
    s2_side_nxt.md2  = {1'b0, rnd28(s1_pxx_r)} + {1'b0, rnd28(s1_pyy_r)};
    s2_side_nxt.mxy  = rnd28(s1_pxy_r);
    s2_side_nxt.mxz  = rnd28(s1_pxz_r);
    s2_side_nxt.myz  = rnd28(s1_pyz_r);
    s2_side_nxt.nxy  = s1_nxy_r;
    s2_side_nxt.nxz  = s1_nxz_r;
    s2_side_nxt.nyz  = s1_nyz_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s_r    <= s1_pxx_r + s1_pyy_r + s1_pzz_r;
      s2_side_r <= s2_side_nxt;
    end
  end

  // stage 3: scale by 1/(4 pi^2), split product
  logic [63:0] s3_ph_r, s3_pl_r;
  side_t       s3_side_r;
  side_t       s3_side_nxt;

  always_comb begin
    s3_side_nxt      = s2_side_r;
    s3_side_nxt.tiny = s2_s_r < ANG_SMALL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ph_r   <= s2_s_r[63:32] * INV_4PI2;
      s3_pl_r   <= s2_s_r[31:0] * INV_4PI2;
      s3_side_r <= s3_side_nxt;
    end
  end

  // stage 4: normalised angle squared, range check
  logic [63:0] s4_usum;
  side_t       s4_side_r;
  side_t       s4_side_nxt;
  assign s4_usum = s3_ph_r + {32'd0, s3_pl_r[63:32]};

  always_comb begin
    s4_side_nxt     = s3_side_r;
    s4_side_nxt.big = s4_usum[63:61] != 3'd0;
    s4_side_nxt.u30 = s4_usum[60:31];
    s4_side_nxt.acc = ZETA_TAIL[8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s4_side_nxt;
    end
  end

  // stages 5..65: two restoring dividers of 2^60, Horner series alongside
  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    logic [30:0] rem1_r;
    logic [31:0] rem2_r;
    logic [60:0] q1_r, q2_r;
    side_t       side_r;
    logic [30:0] rem1_in;
    logic [31:0] rem2_in;
    logic [60:0] q1_in, q2_in;
    side_t       side_in;
    side_t       side_nxt;
    logic [30:0] d1;
    logic [32:0] d2;
    logic [31:0] sh1;
    logic [32:0] sh2;

    if (g == 0) begin : g_first
      assign rem1_in = '0;
      assign rem2_in = '0;
      assign q1_in   = '0;
      assign q2_in   = '0;
      assign side_in = s4_side_r;
    end else begin : g_rest
      assign rem1_in = g_div[g-1].rem1_r;
      assign rem2_in = g_div[g-1].rem2_r;
      assign q1_in   = g_div[g-1].q1_r;
      assign q2_in   = g_div[g-1].q2_r;
      assign side_in = g_div[g-1].side_r;
    end

    // one Horner step per stage over the first eight
    if (g < 8) begin : g_horner
      logic [59:0] hprod;
      assign hprod = side_in.acc * side_in.u30;
      always_comb begin
        side_nxt     = side_in;
        side_nxt.acc = hprod[59:30] + ZETA_TAIL[7 - g];
      end
    end else begin : g_pass
      assign side_nxt = side_in;
    end

    assign d1    = 31'h4000_0000 - {1'b0, side_in.u30};
    assign d2    = 33'h1_0000_0000 - {3'b000, side_in.u30};
    assign sh1   = {rem1_in, (g == 0) ? 1'b1 : 1'b0};
    assign sh2   = {rem2_in, (g == 0) ? 1'b1 : 1'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        // quotient bit 60-g of each divider
        if (sh1 >= {1'b0, d1}) begin
          rem1_r <= 31'(sh1 - {1'b0, d1});
          q1_r   <= q1_in | (61'd1 << (DIV_N - 1 - g));
        end else begin
          rem1_r <= sh1[30:0];
          q1_r   <= q1_in;
        end
        if (sh2 >= d2) begin
          rem2_r <= 32'(sh2 - d2);
          q2_r   <= q2_in | (61'd1 << (DIV_N - 1 - g));
        end else begin
          rem2_r <= sh2[31:0];
          q2_r   <= q2_in;
        end
        side_r <= side_nxt;
      end
    end
  end

  // stage 66: series sum B
  logic [61:0] s5_b_r;
  side_t       s5_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b_r    <= {1'b0, g_div[DIV_N-1].q1_r} + {1'b0, g_div[DIV_N-1].q2_r}
                 + {32'd0, g_div[DIV_N-1].side_r.acc};
      s5_side_r <= g_div[DIV_N-1].side_r;
    end
  end

  // stage 67: B * 1/(2 pi^2), split product
  logic [57:0] s6_ph_r;
  logic [59:0] s6_pl_r;
  side_t       s6_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ph_r   <= s5_b_r[61:32] * INV_2PI2;
      s6_pl_r   <= s5_b_r[31:0] * INV_2PI2;
      s6_side_r <= s5_side_r;
    end
  end

  // stage 68: coefficient c, Q30
  logic [58:0] s7_c_r;
  side_t       s7_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_c_r    <= {1'b0, s6_ph_r} + {31'd0, s6_pl_r[59:32]};
      s7_side_r <= s6_side_r;
    end
  end

  // stage 69: partial products of c times each distinct |m|
  logic [35:0] mm [0:5];
  logic        mn [0:5];
  assign mm[0] = s7_side_r.md0;
  assign mm[1] = s7_side_r.md1;
  assign mm[2] = s7_side_r.md2;
  assign mm[3] = {1'b0, s7_side_r.mxy};
  assign mm[4] = {1'b0, s7_side_r.mxz};
  assign mm[5] = {1'b0, s7_side_r.myz};
  assign mn[0] = 1'b1;
  assign mn[1] = 1'b1;
  assign mn[2] = 1'b1;
  assign mn[3] = s7_side_r.nxy;
  assign mn[4] = s7_side_r.nxz;
  assign mn[5] = s7_side_r.nyz;

  logic [63:0] s8_pll_r [0:5];
  logic [35:0] s8_plh_r [0:5];
  logic [58:0] s8_phl_r [0:5];
  logic [30:0] s8_phh_r [0:5];
  logic        s8_neg_r [0:5];
  side_t       s8_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s8_pll_r[i] <= s7_c_r[31:0] * mm[i][31:0];
        s8_plh_r[i] <= s7_c_r[31:0] * mm[i][35:32];
        s8_phl_r[i] <= s7_c_r[58:32] * mm[i][31:0];
        s8_phh_r[i] <= s7_c_r[58:32] * mm[i][35:32];
        s8_neg_r[i] <= mn[i];
      end
      s8_side_r <= s7_side_r;
    end
  end

  // stage 70: c*|m| / 2^30 rounded, clamped when the product passes 2^62
  logic [95:0] pfull [0:5];
  logic [95:0] prnd  [0:5];
  logic [40:0] tmag  [0:5];
  logic signed [41:0] s9_term_r [0:5];
  side_t       s9_side_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pfull[i] = {s8_phh_r[i], 64'd0}
               + {4'd0, {1'b0, s8_plh_r[i]} + {1'b0, s8_phl_r[i][58:0]}, 32'd0}
               + {32'd0, s8_pll_r[i]};
      prnd[i]  = pfull[i] + 96'h2000_0000;
      tmag[i]  = (pfull[i] > (96'd1 << 62)) ? (41'd1 << 40) : prnd[i][70:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s9_term_r[i] <= s8_neg_r[i] ? -$signed({1'b0, tmag[i]})
                                    : $signed({1'b0, tmag[i]});
      end
      s9_side_r <= s8_side_r;
    end
  end

  // stage 71: assemble entries, saturate, special cases
  logic signed [42:0] one_e;
  logic signed [42:0] e [0:8];
  logic [31:0] s10_j_r [0:8];
  logic        s10_oor_r;

  assign one_e = 43'(ONE_Q28);

  always_comb begin
    e[0] = one_e + 43'(s9_term_r[0]);
    e[1] = 43'(half_of(s9_side_r.vz, 1'b1)) + 43'(s9_term_r[3]);
    e[2] = 43'(half_of(s9_side_r.vy, 1'b0)) + 43'(s9_term_r[4]);
    e[3] = 43'(half_of(s9_side_r.vz, 1'b0)) + 43'(s9_term_r[3]);
    e[4] = one_e + 43'(s9_term_r[1]);
    e[5] = 43'(half_of(s9_side_r.vx, 1'b1)) + 43'(s9_term_r[5]);
    e[6] = 43'(half_of(s9_side_r.vy, 1'b1)) + 43'(s9_term_r[4]);
    e[7] = 43'(half_of(s9_side_r.vx, 1'b0)) + 43'(s9_term_r[5]);
    e[8] = one_e + 43'(s9_term_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        if (s9_side_r.tiny) begin
          s10_j_r[i] <= (i % 4 == 0) ? ONE_Q28 : 32'd0;
        end else if (s9_side_r.big) begin
          s10_j_r[i] <= SAT_POS;
        end else begin
          s10_j_r[i] <= sat32(e[i]);
        end
      end
      s10_oor_r <= !s9_side_r.tiny && s9_side_r.big;
    end
  end

  // output register
  logic         out_valid_r;
  logic [287:0] out_data_r;
  logic         out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld_r[NSTG]) begin
      for (int i = 0; i < 9; i++) begin
        out_data_r[i*32 +: 32] <= s10_j_r[i];
      end
      out_user_r <= s10_oor_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- design/so3ij_chk.sv -----
module so3ij_chk
  import so3ij_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [287:0] out_tdata,
  input logic         out_tuser
);

  // held request keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output request changed while stalled");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input is refused only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // out-of-range results carry positive full scale in j00, j01, j11 and j22
  a_oor_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[31:0] == SAT_POS && out_tdata[159:128] == SAT_POS &&
      out_tdata[287:256] == SAT_POS && out_tdata[63:32] == SAT_POS)
    else $error("out-of-range result not saturated");

endmodule

bind so3_inverse_right_jacobian so3ij_chk u_so3ij_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
